>>> rtl/lrp_pkg.sv
package lrp_pkg;

  // Field widths of the input and result words.
  localparam int REQ_W      = 2;
  localparam int AXIS_W     = 2;
  localparam int IDX_W      = 16;
  localparam int DIR_W      = 18;
  localparam int OFF_W      = 25;
  localparam int ENC_W      = 17;
  localparam int CHAN_W     = 6;
  localparam int RANGE_RAW_W = 32;
  localparam int RANGE_W    = 20;
  localparam int REFL_W     = 16;
  localparam int PT_W       = 26;
  localparam int COL_OUT_W  = 10;
  localparam int TICKS_W    = 16;

  // Fixed-point scaling of the direction times range product.
  localparam int FRAC_SHIFT = 12;

  // Number of beam channels that have table rows.
  localparam int CHANNELS   = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RMIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RMAX  = 2'd2;

  localparam logic [TICKS_W-1:0] TICKS_RESET     = 16'd88;
  localparam logic [RANGE_W-1:0] RANGE_MIN_RESET = '0;
  localparam logic [RANGE_W-1:0] RANGE_MAX_RESET = '1;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_USED = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MEAS = 2'd2;

  // Axis codes.
  localparam int N_AXES = 3;
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_CODES [N_AXES] = '{AXIS_X, AXIS_Y, AXIS_Z};

  // One accepted input word.
  typedef struct packed {
    logic [REQ_W-1:0]          req;
    logic [AXIS_W-1:0]         axis;
    logic [IDX_W-1:0]          tidx;
    logic signed [DIR_W-1:0]   dir;
    logic signed [OFF_W-1:0]   off;
    logic                      flag;
    logic [ENC_W-1:0]          enc;
    logic [CHAN_W-1:0]         chan;
    logic [RANGE_W-1:0]        range;
    logic [REFL_W-1:0]         refl;
  } item_t;

  // One stage of the column divider.
  typedef struct packed {
    logic               vld;
    item_t              item;
    logic [TICKS_W-1:0] rem;
    logic [ENC_W-1:0]   quo;
  } div_stage_t;

  // A point request after the table lookup.
  typedef struct packed {
    logic                    vld;
    logic [RANGE_W-1:0]      range;
    logic [CHAN_W-1:0]       chan;
    logic [COL_OUT_W-1:0]    col;
    logic [REFL_W-1:0]       refl;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] off_z;
  } pt_req_t;

endpackage

>>> rtl/lidar_range_to_point_core.sv
// Path: an accepted input word passes the divider stages, the index stage, the table read stage,
// then the product and output stages of the lanes. Throughput: one word per cycle while the mask
// sweep is done; the pipeline stalls as a whole only while a finished point waits to be taken.
// Reset: synchronous, active low. The used-pixel mask is then swept to zero entry by entry,
// during which in_ready stays low; configuration writes are taken.
module lidar_range_to_point_core import lrp_pkg::*; #(
  parameter int COLUMNS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [AXIS_W-1:0]       in_axis,
  input  logic [IDX_W-1:0]        in_table_index,
  input  logic signed [DIR_W-1:0] in_dir_value,
  input  logic signed [OFF_W-1:0] in_offset_value,
  input  logic                    in_used_flag,
  input  logic [ENC_W-1:0]        in_encoder_count,
  input  logic [CHAN_W-1:0]       in_channel,
  input  logic [RANGE_RAW_W-1:0]  in_range_word,
  input  logic [REFL_W-1:0]       in_reflectivity,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PT_W-1:0]  out_point_x,
  output logic signed [PT_W-1:0]  out_point_y,
  output logic signed [PT_W-1:0]  out_point_z,
  output logic [CHAN_W-1:0]       out_channel_out,
  output logic [COL_OUT_W-1:0]    out_column_out,
  output logic [REFL_W-1:0]       out_intensity_out,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic               adv;
  logic               busy;
  item_t              in_item;
  div_stage_t         div_out;
  pt_req_t            req;
  logic [TICKS_W-1:0] ticks_r;
  logic [RANGE_W-1:0] rmin_r;
  logic [RANGE_W-1:0] rmax_r;

  // The whole pipeline moves unless a finished word is held at the output.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= TICKS_RESET;
      rmin_r  <= RANGE_MIN_RESET;
      rmax_r  <= RANGE_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS: ticks_r <= cfg_wdata[TICKS_W-1:0];
        CFG_RMIN:  rmin_r  <= cfg_wdata[RANGE_W-1:0];
        CFG_RMAX:  rmax_r  <= cfg_wdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the input word; only the low range bits carry millimeters.
  always_comb begin
    in_item.req   = in_req_type;
    in_item.axis  = in_axis;
    in_item.tidx  = in_table_index;
    in_item.dir   = in_dir_value;
    in_item.off   = in_offset_value;
    in_item.flag  = in_used_flag;
    in_item.enc   = in_encoder_count;
    in_item.chan  = in_channel;
    in_item.range = in_range_word[RANGE_W-1:0];
    in_item.refl  = in_reflectivity;
  end

  lrp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ticks   (ticks_r),
    .in_vld  (in_valid && !busy),
    .in_item (in_item),
    .out_stg (div_out)
  );

  lrp_table #(
    .COLUMNS (COLUMNS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ticks (ticks_r),
    .rmin  (rmin_r),
    .rmax  (rmax_r),
    .din   (div_out),
    .busy  (busy),
    .dout  (req)
  );

  lrp_coord u_coord_x (
    .clk   (clk),
    .adv   (adv),
    .dir   (req.dir_x),
    .off   (req.off_x),
    .range (req.range),
    .point (out_point_x)
  );

  lrp_coord u_coord_y (
    .clk   (clk),
    .adv   (adv),
    .dir   (req.dir_y),
    .off   (req.off_y),
    .range (req.range),
    .point (out_point_y)
  );

  lrp_coord u_coord_z (
    .clk   (clk),
    .adv   (adv),
    .dir   (req.dir_z),
    .off   (req.off_z),
    .range (req.range),
    .point (out_point_z)
  );

  // Side band alongside the product and output stages of the lanes.
  logic                 p_vld_r;
  logic [CHAN_W-1:0]    p_chan_r;
  logic [COL_OUT_W-1:0] p_col_r;
  logic [REFL_W-1:0]    p_refl_r;
  logic                 out_valid_r;
  logic [CHAN_W-1:0]    out_chan_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [REFL_W-1:0]    out_refl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p_vld_r     <= req.vld;
      out_valid_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_chan_r   <= req.chan;
      p_col_r    <= req.col;
      p_refl_r   <= req.refl;
      out_chan_r <= p_chan_r;
      out_col_r  <= p_col_r;
      out_refl_r <= p_refl_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_out   = out_chan_r;
  assign out_column_out    = out_col_r;
  assign out_intensity_out = out_refl_r;

endmodule

>>> rtl/lrp_div.sv
module lrp_div import lrp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [TICKS_W-1:0] ticks,
  input  logic               in_vld,
  input  item_t              in_item,
  output div_stage_t         out_stg
);

  // Restoring division, a few quotient bits per stage.
  localparam int STEP  = 3;
  localparam int N_STG = (ENC_W + STEP - 1) / STEP;

  div_stage_t stg_r   [N_STG];
  div_stage_t stg_nxt [N_STG];

  for (genvar s = 0; s < N_STG; s++) begin : g_stg
    div_stage_t prev;
    div_stage_t nxt;

    if (s == 0) begin : g_first
      assign prev = '{vld: in_vld, item: in_item, rem: '0, quo: '0};
    end else begin : g_next
      assign prev = stg_r[s-1];
    end

    // Shift in one dividend bit per step and subtract the divisor when it fits.
    always_comb begin
      logic [TICKS_W:0] trial;
      nxt   = prev;
      trial = '0;
      for (int j = 0; j < STEP; j++) begin
        if (s * STEP + j < ENC_W) begin
          trial = {nxt.rem, nxt.item.enc[ENC_W-1-(s*STEP+j)]};
          if (trial >= {1'b0, ticks}) begin
            trial = trial - {1'b0, ticks};
            nxt.quo[ENC_W-1-(s*STEP+j)] = 1'b1;
          end
          nxt.rem = trial[TICKS_W-1:0];
        end
      end
    end

    assign stg_nxt[s] = nxt;
  end

  // Stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_STG; k++) begin
        stg_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k < N_STG; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_stg = stg_r[N_STG-1];

endmodule

>>> rtl/lrp_table.sv
module lrp_table import lrp_pkg::*; #(
  parameter int COLUMNS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [TICKS_W-1:0] ticks,
  input  logic [RANGE_W-1:0] rmin,
  input  logic [RANGE_W-1:0] rmax,
  input  div_stage_t         din,
  output logic               busy,
  output pt_req_t            dout
);

  localparam int COL_W       = $clog2(COLUMNS);
  localparam int PIX_RAW_W   = CHAN_W + COL_W + 1;
  localparam int PIX_W       = (PIX_RAW_W > IDX_W) ? PIX_RAW_W : IDX_W;
  localparam int STORE_DEPTH = 2 ** IDX_W;
  localparam int AX_W        = DIR_W + OFF_W;

  typedef struct packed {
    logic                    vld;
    logic [REQ_W-1:0]        req;
    logic [AXIS_W-1:0]       axis;
    logic [IDX_W-1:0]        tidx;
    logic signed [DIR_W-1:0] dir;
    logic signed [OFF_W-1:0] off;
    logic                    flag;
    logic                    meas_ok;
    logic [IDX_W-1:0]        pix;
    logic [RANGE_W-1:0]      range;
    logic [CHAN_W-1:0]       chan;
    logic [COL_OUT_W-1:0]    col;
    logic [REFL_W-1:0]       refl;
  } idx_stage_t;

  idx_stage_t idx_r;
  idx_stage_t idx_nxt;
  logic [PIX_W-1:0] pix_full;

  // Index stage: qualify the measurement and form the pixel address.
  always_comb begin
    pix_full = PIX_W'(din.item.chan) * PIX_W'(COLUMNS) + PIX_W'(din.quo[COL_W-1:0]);
    idx_nxt.vld     = din.vld;
    idx_nxt.req     = din.item.req;
    idx_nxt.axis    = din.item.axis;
    idx_nxt.tidx    = din.item.tidx;
    idx_nxt.dir     = din.item.dir;
    idx_nxt.off     = din.item.off;
    idx_nxt.flag    = din.item.flag;
    idx_nxt.meas_ok = (din.item.req == REQ_MEAS) && (ticks != '0) &&
                      (32'(din.quo) < COLUMNS) && (32'(din.item.chan) < CHANNELS) &&
                      (din.item.range >= rmin) && (din.item.range <= rmax);
    idx_nxt.pix     = pix_full[IDX_W-1:0];
    idx_nxt.range   = din.item.range;
    idx_nxt.chan    = din.item.chan;
    idx_nxt.col     = din.quo[COL_OUT_W-1:0];
    idx_nxt.refl    = din.item.refl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r.vld <= 1'b0;
    end else if (adv) begin
      idx_r <= idx_nxt;
    end
  end

  // Used-pixel mask, swept to zero after reset.
  logic             clr_active_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic             used_we;
  logic [IDX_W-1:0] used_wa;
  logic             used_wd;
  logic             used_mem [STORE_DEPTH];
  logic             used_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_comb begin
    used_we = 1'b0;
    used_wa = idx_r.tidx;
    used_wd = idx_r.flag;
    if (clr_active_r) begin
      used_we = 1'b1;
      used_wa = clr_cnt_r;
      used_wd = 1'b0;
    end else if (adv && idx_r.vld && (idx_r.req == REQ_USED)) begin
      used_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    if (adv) begin
      used_rd_r <= used_mem[idx_r.pix];
    end
  end

  // Direction and offset tables, one memory per axis.
  logic [AX_W-1:0] ax_rd [N_AXES];

  for (genvar a = 0; a < N_AXES; a++) begin : g_axis
    logic [AX_W-1:0] mem [STORE_DEPTH];
    logic [AX_W-1:0] rd_r;
    logic            we;

    assign we = adv && idx_r.vld && (idx_r.req == REQ_LOAD) && (idx_r.axis == AXIS_CODES[a]);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[idx_r.tidx] <= {idx_r.dir, idx_r.off};
      end
      if (adv) begin
        rd_r <= mem[idx_r.pix];
      end
    end

    assign ax_rd[a] = rd_r;
  end

  // Read stage side band.
  logic                 rd_vld_r;
  logic [RANGE_W-1:0]   rd_range_r;
  logic [CHAN_W-1:0]    rd_chan_r;
  logic [COL_OUT_W-1:0] rd_col_r;
  logic [REFL_W-1:0]    rd_refl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (adv) begin
      rd_vld_r <= idx_r.vld && idx_r.meas_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_range_r <= idx_r.range;
      rd_chan_r  <= idx_r.chan;
      rd_col_r   <= idx_r.col;
      rd_refl_r  <= idx_r.refl;
    end
  end

  // A point is made only for a used pixel.
  always_comb begin
    dout.vld   = rd_vld_r && used_rd_r;
    dout.range = rd_range_r;
    dout.chan  = rd_chan_r;
    dout.col   = rd_col_r;
    dout.refl  = rd_refl_r;
    dout.dir_x = ax_rd[0][AX_W-1:OFF_W];
    dout.dir_y = ax_rd[1][AX_W-1:OFF_W];
    dout.dir_z = ax_rd[2][AX_W-1:OFF_W];
    dout.off_x = ax_rd[0][OFF_W-1:0];
    dout.off_y = ax_rd[1][OFF_W-1:0];
    dout.off_z = ax_rd[2][OFF_W-1:0];
  end

  assign busy = clr_active_r;

endmodule

>>> rtl/lrp_coord.sv
module lrp_coord import lrp_pkg::*; (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [DIR_W-1:0] dir,
  input  logic signed [OFF_W-1:0] off,
  input  logic [RANGE_W-1:0]      range,
  output logic signed [PT_W-1:0]  point
);

  localparam int PROD_W = DIR_W + RANGE_W + 1;
  localparam int SH_W   = PROD_W - FRAC_SHIFT;
  localparam int SUM_W  = SH_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2 ** (PT_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(2 ** (PT_W - 1)));

  logic signed [PROD_W-1:0] prod_r;
  logic signed [OFF_W-1:0]  off_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [PT_W-1:0]   point_nxt;
  logic signed [PT_W-1:0]   point_r;

  // Floor shift of the product, offset add and saturation.
  always_comb begin
    sum = SUM_W'($signed(prod_r[PROD_W-1:FRAC_SHIFT])) + SUM_W'(off_r);
    if (sum > SUM_MAX) begin
      point_nxt = SUM_MAX[PT_W-1:0];
    end else if (sum < SUM_MIN) begin
      point_nxt = SUM_MIN[PT_W-1:0];
    end else begin
      point_nxt = sum[PT_W-1:0];
    end
  end

  // Product stage, then output stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= PROD_W'(dir) * PROD_W'($signed({1'b0, range}));
      off_r   <= off;
      point_r <= point_nxt;
    end
  end

  assign point = point_r;

endmodule

>>> tb/sv/lrp_point_checker.sv
module lrp_point_checker import lrp_pkg::*; #(
  parameter int COLUMNS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic [AXIS_W-1:0]       in_axis,
  input  logic [IDX_W-1:0]        in_table_index,
  input  logic signed [DIR_W-1:0] in_dir_value,
  input  logic signed [OFF_W-1:0] in_offset_value,
  input  logic                    in_used_flag,
  input  logic [ENC_W-1:0]        in_encoder_count,
  input  logic [CHAN_W-1:0]       in_channel,
  input  logic [RANGE_RAW_W-1:0]  in_range_word,
  input  logic [REFL_W-1:0]       in_reflectivity,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [PT_W-1:0]  out_point_x,
  input  logic signed [PT_W-1:0]  out_point_y,
  input  logic signed [PT_W-1:0]  out_point_z,
  input  logic [CHAN_W-1:0]       out_channel_out,
  input  logic [COL_OUT_W-1:0]    out_column_out,
  input  logic [REFL_W-1:0]       out_intensity_out,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output int                      fail_count,
  output int                      pending
);

  localparam longint PT_MAX = (longint'(1) <<< (PT_W - 1)) - 1;
  localparam longint PT_MIN = -(longint'(1) <<< (PT_W - 1));

  typedef struct {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic signed [PT_W-1:0] z;
    logic [CHAN_W-1:0]      chan;
    logic [COL_OUT_W-1:0]   col;
    logic [REFL_W-1:0]      refl;
  } point_t;

  // Shadow of the pixel table, the used-pixel mask and the registers.
  logic signed [DIR_W-1:0] dir_tab [N_AXES][1<<IDX_W];
  logic signed [OFF_W-1:0] off_tab [N_AXES][1<<IDX_W];
  bit                      used_tab [1<<IDX_W];
  logic [TICKS_W-1:0]      ticks;
  logic [RANGE_W-1:0]      gate_lo;
  logic [RANGE_W-1:0]      gate_hi;

  // Points still owed by the block, oldest first.
  point_t points_due [$];

  // One coordinate: direction times range, floored to whole millimetres, plus offset, clamped.
  function automatic logic signed [PT_W-1:0] axis_coord(input logic signed [DIR_W-1:0] d,
                                                        input logic signed [OFF_W-1:0] o,
                                                        input logic [RANGE_W-1:0] r);
    longint v;
    v = ((longint'(d) * longint'(r)) >>> FRAC_SHIFT) + longint'(o);
    if (v > PT_MAX) v = PT_MAX;
    if (v < PT_MIN) v = PT_MIN;
    return v[PT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", what, got, want));
  endtask

  // Apply one accepted input word to the shadow state and queue its point, if any.
  task automatic take_word();
    int                 col;
    logic [IDX_W-1:0]   pix;
    logic [RANGE_W-1:0] r;
    point_t             p;
    r = in_range_word[RANGE_W-1:0];
    case (in_req_type)
      REQ_LOAD: begin
        if (in_axis < N_AXES) begin
          dir_tab[in_axis][in_table_index] = in_dir_value;
          off_tab[in_axis][in_table_index] = in_offset_value;
        end
      end
      REQ_USED: begin
        used_tab[in_table_index] = in_used_flag;
      end
      REQ_MEAS: begin
        if (ticks != 0) begin
          col = int'(in_encoder_count / ticks);
          pix = IDX_W'(int'(in_channel) * COLUMNS + col);
          if (col < COLUMNS && in_channel < CHANNELS && used_tab[pix] &&
              r >= gate_lo && r <= gate_hi) begin
            p.x = axis_coord(dir_tab[AXIS_X][pix], off_tab[AXIS_X][pix], r);
            p.y = axis_coord(dir_tab[AXIS_Y][pix], off_tab[AXIS_Y][pix], r);
            p.z = axis_coord(dir_tab[AXIS_Z][pix], off_tab[AXIS_Z][pix], r);
            p.chan = in_channel;
            p.col = COL_OUT_W'(col);
            p.refl = in_reflectivity;
            points_due.insert(points_due.size(), p);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Compare one accepted point against the oldest one owed.
  task automatic check_point();
    point_t want;
    if (points_due.size() == 0) begin
      report_mismatch("point with none expected");
    end else begin
      want = points_due.pop_front();
      check_field("point_x", 32'(out_point_x), 32'(want.x));
      check_field("point_y", 32'(out_point_y), 32'(want.y));
      check_field("point_z", 32'(out_point_z), 32'(want.z));
      check_field("channel", 32'(out_channel_out), 32'(want.chan));
      check_field("column", 32'(out_column_out), 32'(want.col));
      check_field("intensity", 32'(out_intensity_out), 32'(want.refl));
    end
  endtask

  // Everything is driven at the rising edge, so the falling edge sees settled values.
  always @(negedge clk) begin
    if (!rst_n) begin
      foreach (used_tab[i]) used_tab[i] = 1'b0;
      ticks = TICKS_RESET;
      gate_lo = RANGE_MIN_RESET;
      gate_hi = RANGE_MAX_RESET;
      points_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICKS: ticks = cfg_wdata[TICKS_W-1:0];
          CFG_RMIN:  gate_lo = cfg_wdata[RANGE_W-1:0];
          CFG_RMAX:  gate_hi = cfg_wdata[RANGE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_point();
      if (in_valid && in_ready) take_word();
    end
    pending = points_due.size();
  end

endmodule

>>> tb/sv/lidar_range_to_point_core_tb.sv
module lidar_range_to_point_core_tb import lrp_pkg::*;;

  localparam int COLUMNS     = 1024;
  localparam int PIPE_DRAIN  = 16;
  localparam int STALL_LIMIT = 300000;
  localparam int POOL_MAX    = 48;
  localparam int ENC_MAX     = (1 << ENC_W) - 1;

  // Codes the block must ignore.
  localparam logic [REQ_W-1:0]     REQ_SPARE = 2'd3;
  localparam logic [AXIS_W-1:0]    AXIS_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [N_AXES-1:0]    ALL_AXES  = '1;
  localparam logic [IDX_W-1:0]     PIX_FIRST = '0;
  localparam logic [IDX_W-1:0]     PIX_LAST  = '1;

  localparam logic signed [DIR_W-1:0] DIR_MAX = {1'b0, {(DIR_W-1){1'b1}}};
  localparam logic signed [DIR_W-1:0] DIR_MIN = {1'b1, {(DIR_W-1){1'b0}}};
  localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
  localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

  // Register settings run one after another; the second runs without any idling.
  localparam int N_PHASES    = 9;
  localparam int QUIET_PHASE = 1;
  localparam int PH_TICKS [N_PHASES] = '{88, 1, 65535, 100, 88, 0, 88, 300, 1024};
  localparam int PH_RMIN  [N_PHASES] = '{0, 0, 0, 5000, 1048575, 0, 200000, 0, 0};
  localparam int PH_RMAX  [N_PHASES] =
    '{1048575, 1048575, 1048575, 300000, 1048575, 1048575, 100, 0, 1048575};
  localparam int PH_ITEMS [N_PHASES] = '{400, 250, 150, 300, 100, 60, 60, 80, 330};

  typedef struct packed {
    logic [REQ_W-1:0]         req;
    logic [AXIS_W-1:0]        axis;
    logic [IDX_W-1:0]         tidx;
    logic signed [DIR_W-1:0]  dir;
    logic signed [OFF_W-1:0]  off;
    logic                     flag;
    logic [ENC_W-1:0]         enc;
    logic [CHAN_W-1:0]        chan;
    logic [RANGE_RAW_W-1:0]   range_word;
    logic [REFL_W-1:0]        refl;
  } in_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [REQ_W-1:0]        in_req_type = '0;
  logic [AXIS_W-1:0]       in_axis = '0;
  logic [IDX_W-1:0]        in_table_index = '0;
  logic signed [DIR_W-1:0] in_dir_value = '0;
  logic signed [OFF_W-1:0] in_offset_value = '0;
  logic                    in_used_flag = 1'b0;
  logic [ENC_W-1:0]        in_encoder_count = '0;
  logic [CHAN_W-1:0]       in_channel = '0;
  logic [RANGE_RAW_W-1:0]  in_range_word = '0;
  logic [REFL_W-1:0]       in_reflectivity = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [PT_W-1:0]  out_point_x;
  logic signed [PT_W-1:0]  out_point_y;
  logic signed [PT_W-1:0]  out_point_z;
  logic [CHAN_W-1:0]       out_channel_out;
  logic [COL_OUT_W-1:0]    out_column_out;
  logic [REFL_W-1:0]       out_intensity_out;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  int fail_count;
  int pending;

  // Stimulus bookkeeping: register values in force, words sent, pixels loaded.
  bit                no_idle = 1'b0;
  int                items_sent = 0;
  int                idle_cycles = 0;
  int                cur_ticks = int'(TICKS_RESET);
  int                cur_rmin = int'(RANGE_MIN_RESET);
  int                cur_rmax = int'(RANGE_MAX_RESET);
  logic [N_AXES-1:0] loaded [1<<IDX_W];
  logic [IDX_W-1:0]  pool [$];

  lidar_range_to_point_core #(.COLUMNS(COLUMNS)) uut (.*);

  lrp_point_checker #(.COLUMNS(COLUMNS)) checker_i (.*);

  always #4 clk = ~clk;

  // Result side: accept about 84 points in a hundred, all of them in the quiet phase.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 16);
  end

  // Give up when nothing moves on either channel for too long.
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_word_t noise_word();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(in_word_t)-1:0];
  endfunction

  function automatic logic signed [DIR_W-1:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return DIR_MAX;
      1: return DIR_MIN;
      default: return DIR_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [OFF_W-1:0] rand_off();
    case ($urandom_range(0, 9))
      0: return OFF_MAX;
      1: return OFF_MIN;
      default: return OFF_W'($urandom);
    endcase
  endfunction

  // Present one word, with an occasional gap first, and wait for it to be taken.
  task automatic send_word(input in_word_t w);
    if (!no_idle && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    in_valid <= 1'b1;
    in_req_type <= w.req;
    in_axis <= w.axis;
    in_table_index <= w.tidx;
    in_dir_value <= w.dir;
    in_offset_value <= w.off;
    in_used_flag <= w.flag;
    in_encoder_count <= w.enc;
    in_channel <= w.chan;
    in_range_word <= w.range_word;
    in_reflectivity <= w.refl;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (w.req != REQ_SPARE && !(w.req == REQ_LOAD && w.axis == AXIS_NONE)) items_sent++;
  endtask

  task automatic load_axis(input logic [IDX_W-1:0] idx, input logic [AXIS_W-1:0] axis,
                           input logic signed [DIR_W-1:0] dir,
                           input logic signed [OFF_W-1:0] off);
    in_word_t w;
    w = noise_word();
    w.req = REQ_LOAD;
    w.axis = axis;
    w.tidx = idx;
    w.dir = dir;
    w.off = off;
    send_word(w);
    if (axis < N_AXES) loaded[idx][axis] = 1'b1;
  endtask

  task automatic set_used(input logic [IDX_W-1:0] idx, input logic flag);
    in_word_t w;
    w = noise_word();
    w.req = REQ_USED;
    w.tidx = idx;
    w.flag = flag;
    send_word(w);
  endtask

  task automatic measure(input logic [ENC_W-1:0] enc, input logic [CHAN_W-1:0] chan,
                         input logic [RANGE_RAW_W-1:0] rw, input logic [REFL_W-1:0] refl);
    in_word_t w;
    w = noise_word();
    w.req = REQ_MEAS;
    w.enc = enc;
    w.chan = chan;
    w.range_word = rw;
    w.refl = refl;
    send_word(w);
  endtask

  // Hold off until every owed point is out and the pipeline has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  initial begin
    int                     goal;
    int                     pick;
    int                     col;
    int                     base;
    int                     span;
    int                     sel;
    logic [IDX_W-1:0]       px;
    logic [CFG_DATA_W-1:0]  tdata;
    logic [RANGE_RAW_W-1:0] rw;
    in_word_t               w;

    foreach (loaded[i]) loaded[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // First pixel: full-scale directions and offsets of both signs.
    load_axis(PIX_FIRST, AXIS_X, DIR_MAX, OFF_MAX);
    load_axis(PIX_FIRST, AXIS_Y, DIR_MIN, OFF_MIN);
    load_axis(PIX_FIRST, AXIS_Z, '0, '0);
    // Last pixel: a tiny negative direction that floors, and unit scales.
    load_axis(PIX_LAST, AXIS_X, -18'sd1, 25'sd5);
    load_axis(PIX_LAST, AXIS_Y, 18'sd4096, OFF_MIN);
    load_axis(PIX_LAST, AXIS_Z, 18'sd65536, OFF_MAX);
    set_used(PIX_FIRST, 1'b1);
    set_used(PIX_LAST, 1'b1);

    // Words the block ignores: a load to no axis and the spare request code.
    w = noise_word();
    w.req = REQ_LOAD;
    w.axis = AXIS_NONE;
    w.tidx = PIX_FIRST;
    send_word(w);
    w = noise_word();
    w.req = REQ_SPARE;
    send_word(w);

    // Full range with junk above the millimetre bits saturates both ways.
    measure(ENC_W'(int'(TICKS_RESET) - 1), '0, '1, '0);
    // Zero range leaves only the offsets.
    measure('0, '0, 32'hFFF0_0000, '1);
    // Last column of the last channel.
    measure(ENC_W'((COLUMNS - 1) * int'(TICKS_RESET) + int'(TICKS_RESET) - 1), '1,
            32'd100, 16'hA5A5);
    // Encoder past the end of the row, then a pixel never marked used.
    measure('1, '0, $urandom, REFL_W'($urandom));
    measure(ENC_W'(5 * int'(TICKS_RESET)), CHAN_W'(5), $urandom, REFL_W'($urandom));
    // Clearing the used flag drops the pixel until it is set again.
    set_used(PIX_FIRST, 1'b0);
    measure('0, '0, $urandom, REFL_W'($urandom));
    set_used(PIX_FIRST, 1'b1);
    measure(ENC_W'(40), '0, $urandom, REFL_W'($urandom));
    pool.insert(pool.size(), PIX_FIRST);
    pool.insert(pool.size(), PIX_LAST);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      cur_ticks = PH_TICKS[ph];
      cur_rmin = PH_RMIN[ph];
      cur_rmax = PH_RMAX[ph];
      tdata = CFG_DATA_W'($urandom);
      tdata[TICKS_W-1:0] = TICKS_W'(cur_ticks);
      write_reg(CFG_TICKS, tdata);
      write_reg(CFG_RMIN, CFG_DATA_W'(cur_rmin));
      write_reg(CFG_RMAX, CFG_DATA_W'(cur_rmax));
      write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;
      no_idle <= (ph == QUIET_PHASE);
      goal = items_sent + PH_ITEMS[ph];

      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // New pixel: all three axes, then mark it used.
          px = IDX_W'($urandom);
          for (int a = 0; a < N_AXES; a++) load_axis(px, AXIS_CODES[a], rand_dir(), rand_off());
          set_used(px, 1'b1);
          pool.insert(pool.size(), px);
          if (pool.size() > POOL_MAX) void'(pool.pop_front());
        end else if (pick < 72) begin
          // Measurement aimed at a known pixel, range mostly inside the gate.
          px = pool[$urandom_range(0, pool.size() - 1)];
          col = px % COLUMNS;
          base = col * cur_ticks;
          rw = $urandom;
          sel = $urandom_range(0, 19);
          if (cur_rmin <= cur_rmax) begin
            if (sel == 0) rw[RANGE_W-1:0] = RANGE_W'(cur_rmin);
            else if (sel == 1) rw[RANGE_W-1:0] = RANGE_W'(cur_rmax);
            else if (sel == 2) rw[RANGE_W-1:0] = RANGE_W'(cur_rmin - 1);
            else if (sel == 3) rw[RANGE_W-1:0] = RANGE_W'(cur_rmax + 1);
            else if (sel < 17) rw[RANGE_W-1:0] = RANGE_W'($urandom_range(cur_rmax, cur_rmin));
          end
          if (cur_ticks != 0 && base <= ENC_MAX) begin
            span = cur_ticks - 1;
            if (span > ENC_MAX - base) span = ENC_MAX - base;
            measure(ENC_W'(base + $urandom_range(0, span)), CHAN_W'(px / COLUMNS), rw,
                    REFL_W'($urandom));
          end else begin
            measure(ENC_W'($urandom), CHAN_W'(px / COLUMNS), rw, REFL_W'($urandom));
          end
        end else if (pick < 82) begin
          measure(ENC_W'($urandom), CHAN_W'($urandom), $urandom, REFL_W'($urandom));
        end else if (pick < 87) begin
          // Stray load anywhere, the ignored axis code included.
          load_axis(IDX_W'($urandom), AXIS_W'($urandom_range(0, 3)), rand_dir(), rand_off());
        end else if (pick < 92) begin
          // Used flag: only a fully loaded pixel may be marked used.
          if ($urandom_range(0, 1)) px = pool[$urandom_range(0, pool.size() - 1)];
          else px = IDX_W'($urandom);
          set_used(px, (loaded[px] == ALL_AXES) ? 1'($urandom) : 1'b0);
        end else if (pick < 96) begin
          // Reload one axis of a pixel in use.
          px = pool[$urandom_range(0, pool.size() - 1)];
          load_axis(px, AXIS_CODES[$urandom_range(0, N_AXES - 1)], rand_dir(), rand_off());
        end else begin
          w = noise_word();
          w.req = REQ_SPARE;
          send_word(w);
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
